>>> rtl/vrit_pkg.sv
// ----------------------------------------------------------------------------
// vrit_pkg
// shared types and constants for the raster, interrupt and bus timing block
// ----------------------------------------------------------------------------
package vrit_pkg;

	localparam int FIRST_BAD_LINE = 48;
	localparam int LAST_BAD_LINE = 247;
	localparam int SPRITE_COUNT = 8;

	typedef enum logic [1:0] {
		CMD_TICK  = 2'd0,
		CMD_READ  = 2'd1,
		CMD_WRITE = 2'd2,
		CMD_PEN   = 2'd3
	} cmd_t;

	localparam logic [5:0] REG_CTRL1 = 6'h11;
	localparam logic [5:0] REG_RASTER = 6'h12;
	localparam logic [5:0] REG_PENX = 6'h13;
	localparam logic [5:0] REG_PENY = 6'h14;
	localparam logic [5:0] REG_SPEN = 6'h15;
	localparam logic [5:0] REG_YEXP = 6'h17;
	localparam logic [5:0] REG_IRQ = 6'h19;
	localparam logic [5:0] REG_IMASK = 6'h1a;

	localparam logic CFG_LINES = 1'b0;
	localparam logic CFG_CYCLES = 1'b1;

	typedef struct packed {
		logic [1:0] cmd;
		logic [5:0] addr;
		logic [7:0] wdata;
	} in_item_t;

	typedef struct packed {
		logic [7:0] rdata;
		logic       irq_line;
		logic       bus_available;
	} out_item_t;

endpackage

>>> rtl/video_raster_irq_dma_timing.sv
// ----------------------------------------------------------------------------
// video_raster_irq_dma_timing
// raster line, interrupt and bus timing block with register file
// ----------------------------------------------------------------------------
// One item per clock: every tick, register access or pen strobe is handled by
// the state update logic and its result is held in the output registers from
// the next cycle on. The input is stalled while those registers hold a result
// that the downstream side has not yet taken, and after each cycles_per_line
// write while the next line cycle and action position are reduced to the new
// line length.
module video_raster_irq_dma_timing (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  vrit_pkg::in_item_t  in_item,
	output logic                out_valid,
	input  logic                out_stall,
	output vrit_pkg::out_item_t out_item,
	input  logic                cfg_we,
	input  logic                cfg_index,
	input  logic [8:0]          cfg_wdata
);

	logic [8:0] lines_q;
	logic [6:0] cycles_q;
	logic       go;
	logic       cyc_wr;
	logic       busy;
	vrit_pkg::out_item_t res;

	assign in_stall = busy || (out_valid && out_stall);
	assign go = in_valid && !in_stall;
	assign cyc_wr = cfg_we && cfg_index == vrit_pkg::CFG_CYCLES;
	assign out_item = res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lines_q <= 9'd312;
			cycles_q <= 7'd63;
		end else if (cfg_we) begin
			if (cfg_index == vrit_pkg::CFG_LINES) lines_q <= cfg_wdata;
			else cycles_q <= cfg_wdata[6:0];
		end
	end

	vrit_core u_core (
		.clk(clk), .arst_n(arst_n), .go(go), .restart(cyc_wr), .item(in_item),
		.lines_per_frame(lines_q), .cycles_per_line(cycles_q), .busy(busy), .res(res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid <= 1'b0;
		else if (!out_valid || !out_stall) out_valid <= go;
	end

endmodule

>>> rtl/vrit_core.sv
// ----------------------------------------------------------------------------
// vrit_core
// state of the raster timing block, updated once per accepted item and after a line length change
// ----------------------------------------------------------------------------
module vrit_core (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 go,
	input  logic                 restart,
	input  vrit_pkg::in_item_t   item,
	input  logic [8:0]           lines_per_frame,
	input  logic [6:0]           cycles_per_line,
	output logic                 busy,
	output vrit_pkg::out_item_t  res
);

	logic [7:0] rf_q [64];
	logic [7:0] rf_rd_q;
	logic [63:0] vld_q;
	logic [7:0] ctrl1_q, spen_q, yexp_q;
	logic [7:0] spy_q [8];
	logic [6:0] lc_q;
	logic [8:0] rl_q, rc_q;
	logic [2:0] fsy_q;
	logic       bla_q, bln_q, vb_q, pl_q, bus_q;
	logic [7:0] px_q, py_q, fl_q, dma_q, tog_q;
	logic [3:0] mask_q;
	logic [7:0] sbc_q [8];
	logic [7:0] rd_q;
	logic       mem_q;

	logic [7:0] nlc_q, npos_q, rem1_q, rem2_q, div1_q, div2_q;
	logic [2:0] step_q;
	logic       busy_q;
	logic [7:0] nlc_inc, npos_inc, step1, step2;
	logic [6:0] lc_ld;

	logic [6:0] lc_n_o;
	logic [6:0] pos;
	logic [8:0] rl_n, rc_n, last_line, rl_inc;
	logic [2:0] fsy_n;
	logic       bla_n, bln_n, vb_n, pl_n, bus_n, mem_n;
	logic [7:0] px_n, py_n, fl_n, dma_n, tog_n, rd, yexp, en, nd;
	logic [3:0] mask_n;
	logic [7:0] sbc_n [8];
	logic [7:0] m;
	logic       den;

	assign m = (cycles_per_line == 7'd0) ? 8'd128 : {1'b0, cycles_per_line};
	assign last_line = lines_per_frame - 9'd1;
	assign den = ctrl1_q[4];
	assign busy = busy_q;
	assign res = {rd_q | (mem_q ? rf_rd_q : 8'h00), fl_q[7], bus_q};

	function automatic logic [7:0] rem_step(input logic [7:0] r, input logic b,
		input logic [7:0] md);
		logic [7:0] t;
		t = {r[6:0], b};
		return (t >= md) ? t - md : t;
	endfunction

	always_comb begin
		rl_inc = rl_q + 9'd1;
		nlc_inc = (nlc_q + 8'd1 == m) ? 8'd0 : nlc_q + 8'd1;
		npos_inc = (npos_q + 8'd1 == m) ? 8'd0 : npos_q + 8'd1;
		pos = npos_q[6:0];
		lc_ld = go ? lc_n_o : lc_q;
		step1 = rem_step(rem1_q, div1_q[7], m);
		step2 = rem_step(rem2_q, div2_q[7], m);
	end

	always_comb begin
		lc_n_o = lc_q; rl_n = rl_q; rc_n = rc_q; fsy_n = fsy_q; bla_n = bla_q;
		bln_n = bln_q; vb_n = vb_q; pl_n = pl_q; bus_n = bus_q; px_n = px_q;
		py_n = py_q; fl_n = fl_q; dma_n = dma_q; tog_n = tog_q; mask_n = mask_q;
		rd = '0; mem_n = 1'b0; yexp = yexp_q; en = spen_q;
		nd = '0;
		for (int i = 0; i < 8; i++) sbc_n[i] = sbc_q[i];
		case (vrit_pkg::cmd_t'(item.cmd))
			vrit_pkg::CMD_TICK: begin
				lc_n_o = nlc_q[6:0];
				case (pos)
					7'd0: begin
						tog_n = tog_q ^ yexp;
						dma_n = dma_q;
						for (int i = 0; i < 8; i++)
							if (en[i] && rl_q[7:0] == spy_q[i]) begin
								dma_n[i] = 1'b1;
								sbc_n[i] = '0;
								if (yexp[i]) tog_n[i] = 1'b0;
							end
						bus_n = !dma_n[0];
					end
					7'd2:  if (dma_q[1]) bus_n = 1'b0;
					7'd3:  if (dma_q[1:0] == 2'b0) bus_n = 1'b1;
					7'd4:  if (dma_q[2]) bus_n = 1'b0;
					7'd5:  if (dma_q[2:1] == 2'b0) bus_n = 1'b1;
					7'd6:  if (dma_q[3]) bus_n = 1'b0;
					7'd7:  if (dma_q[3:2] == 2'b0) bus_n = 1'b1;
					7'd8:  if (dma_q[4]) bus_n = 1'b0;
					7'd9: begin
						if (rl_q == last_line) vb_n = 1'b1;
						else begin
							rl_n = rl_inc;
							if (rl_inc == rc_q) fl_n[0] = 1'b1;
						end
						if (dma_q[4:3] == 2'b0) bus_n = 1'b1;
					end
					7'd10: begin
						if (vb_q) begin
							vb_n = 1'b0; pl_n = 1'b0; rl_n = '0;
							if (rc_q == 9'd0) fl_n[0] = 1'b1;
						end
						if (dma_q[5]) bus_n = 1'b0;
					end
					7'd11: if (dma_q[5:4] == 2'b0) bus_n = 1'b1;
					7'd12: if (dma_q[6]) bus_n = 1'b0;
					7'd13: if (dma_q[6:5] == 2'b0) bus_n = 1'b1;
					7'd14: if (dma_q[7]) bus_n = 1'b0;
					7'd15: if (dma_q[7:6] == 2'b0) bus_n = 1'b1;
					7'd17: if (!dma_q[7]) bus_n = 1'b1;
					7'd19: bus_n = 1'b1;
					7'd20: begin
						if (rl_q == 9'(vrit_pkg::FIRST_BAD_LINE)) bla_n = den;
						bln_n = rl_q >= 9'(vrit_pkg::FIRST_BAD_LINE)
							&& rl_q <= 9'(vrit_pkg::LAST_BAD_LINE)
							&& rl_q[2:0] == fsy_q && bla_n;
						if (bln_n) bus_n = 1'b0;
					end
					7'd23: for (int i = 0; i < 8; i++)
						if (tog_q[i]) sbc_n[i] = sbc_q[i] + 8'd2;
					7'd24: for (int i = 0; i < 8; i++) begin
						if (tog_q[i]) sbc_n[i] = sbc_q[i] + 8'd1;
						if (sbc_n[i][5:0] == 6'h3f) dma_n[i] = 1'b0;
					end
					7'd63: bus_n = 1'b1;
					default: ;
				endcase
			end
			vrit_pkg::CMD_READ: begin
				case (item.addr)
					vrit_pkg::REG_CTRL1: rd = {rl_q[8], ctrl1_q[6:0]};
					vrit_pkg::REG_RASTER: rd = rl_q[7:0];
					vrit_pkg::REG_PENX: rd = px_q;
					vrit_pkg::REG_PENY: rd = py_q;
					vrit_pkg::REG_IRQ: rd = fl_q | 8'h70;
					vrit_pkg::REG_IMASK: rd = {4'hf, mask_q};
					default: begin
						if (item.addr < 6'h20) mem_n = vld_q[item.addr];
						else if (item.addr < 6'h2f) begin
							rd = 8'hf0;
							mem_n = vld_q[item.addr];
						end
						else rd = 8'hff;
					end
				endcase
			end
			vrit_pkg::CMD_WRITE: begin
				nd = item.wdata;
				case (item.addr)
					vrit_pkg::REG_CTRL1: begin
						rc_n[8] = nd[7];
						fsy_n = nd[2:0];
						if (lc_q >= 7'd11) begin
							if (rl_q == 9'(vrit_pkg::FIRST_BAD_LINE) && nd[4]) bla_n = 1'b1;
							bln_n = rl_q >= 9'(vrit_pkg::FIRST_BAD_LINE)
								&& rl_q <= 9'(vrit_pkg::LAST_BAD_LINE)
								&& rl_q[2:0] == nd[2:0] && bla_n;
							if (bln_n && lc_q < 7'd53) bus_n = 1'b0;
						end
					end
					vrit_pkg::REG_RASTER: rc_n[7:0] = nd;
					vrit_pkg::REG_YEXP: tog_n = tog_q | ~nd;
					vrit_pkg::REG_IRQ: fl_n[3:0] = fl_q[3:0] & ~nd[3:0];
					vrit_pkg::REG_IMASK: mask_n = nd[3:0];
					default: ;
				endcase
			end
			default: begin
				if (!pl_q) begin
					px_n = {lc_q[5:0], 2'b00};
					py_n = rl_q[7:0];
					pl_n = 1'b1;
					fl_n[3] = 1'b1;
				end
			end
		endcase
		fl_n[7] = (fl_n[3:0] & mask_n) != 4'd0;
	end

	always_ff @(posedge clk) begin
		if (go && item.cmd == vrit_pkg::CMD_WRITE) rf_q[item.addr] <= item.wdata;
		if (go) rf_rd_q <= rf_q[item.addr];
	end

	// copies of the registers that the raster logic reads at fixed places
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl1_q <= '0; spen_q <= '0; yexp_q <= '0; vld_q <= '0;
			for (int i = 0; i < 8; i++) spy_q[i] <= '0;
		end else if (go && item.cmd == vrit_pkg::CMD_WRITE) begin
			vld_q[item.addr] <= 1'b1;
			if (item.addr == vrit_pkg::REG_CTRL1) ctrl1_q <= item.wdata;
			if (item.addr == vrit_pkg::REG_SPEN) spen_q <= item.wdata;
			if (item.addr == vrit_pkg::REG_YEXP) yexp_q <= item.wdata;
			if (item.addr[5:4] == 2'b00 && item.addr[0]) spy_q[item.addr[3:1]] <= item.wdata;
		end
	end

	// next line cycle and action position, re-reduced after a line length change
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nlc_q <= 8'd1; npos_q <= 8'd10; busy_q <= 1'b0; step_q <= '0;
			rem1_q <= '0; rem2_q <= '0; div1_q <= '0; div2_q <= '0;
		end else if (restart) begin
			busy_q <= 1'b1; step_q <= '0; rem1_q <= '0; rem2_q <= '0;
			div1_q <= {1'b0, lc_ld} + 8'd1;
			div2_q <= {1'b0, lc_ld} + 8'd10;
		end else if (busy_q) begin
			rem1_q <= step1; rem2_q <= step2;
			div1_q <= {div1_q[6:0], 1'b0}; div2_q <= {div2_q[6:0], 1'b0};
			step_q <= step_q + 3'd1;
			if (step_q == 3'd7) begin
				busy_q <= 1'b0;
				nlc_q <= step1;
				npos_q <= step2;
			end
		end else if (go && item.cmd == vrit_pkg::CMD_TICK) begin
			nlc_q <= nlc_inc;
			npos_q <= npos_inc;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lc_q <= '0; rl_q <= 9'd311; rc_q <= '0; fsy_q <= '0; bla_q <= 1'b0;
			bln_q <= 1'b0; vb_q <= 1'b0; pl_q <= 1'b0; bus_q <= 1'b1; px_q <= '0;
			py_q <= '0; fl_q <= '0; dma_q <= '0; tog_q <= 8'hff; mask_q <= '0;
			rd_q <= '0; mem_q <= 1'b0;
			for (int i = 0; i < 8; i++) sbc_q[i] <= '0;
		end else if (go) begin
			lc_q <= lc_n_o; rl_q <= rl_n; rc_q <= rc_n; fsy_q <= fsy_n; bla_q <= bla_n;
			bln_q <= bln_n; vb_q <= vb_n; pl_q <= pl_n; bus_q <= bus_n; px_q <= px_n;
			py_q <= py_n; fl_q <= fl_n; dma_q <= dma_n; tog_q <= tog_n; mask_q <= mask_n;
			rd_q <= rd; mem_q <= mem_n;
			for (int i = 0; i < 8; i++) sbc_q[i] <= sbc_n[i];
		end
	end

`ifndef NO_ASSERTIONS
	a_irq_consistent: assert property (@(posedge clk) disable iff (!arst_n)
		fl_q[7] == ((fl_q[3:0] & mask_q) != 4'd0)) else $error("irq bit inconsistent");
	a_pen_once: assert property (@(posedge clk) disable iff (!arst_n)
		$past(pl_q) && pl_q |-> $stable(px_q)) else $error("pen relatched");
	a_flags_hi: assert property (@(posedge clk) disable iff (!arst_n)
		fl_q[6:4] == 3'd0) else $error("unused flag bits set");
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> !go) else $error("item taken while line position is reduced");
	a_cycle_range: assert property (@(posedge clk) disable iff (!arst_n)
		!busy_q |-> (nlc_q < m && npos_q < m)) else $error("line position out of range");
`endif

endmodule
